### hw/rtl/sharable_exe_page_loader_top_macros.svh
// ----------------------------------------------------------------------------
// sharable exe page loader assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SHARABLE_EXE_PAGE_LOADER_TOP_MACROS_SVH
`define SHARABLE_EXE_PAGE_LOADER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define SEPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked in every cycle, reset included
`define SEPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEPL_ASSERT(lbl, clk, rst, prop, msg)
`define SEPL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/sepl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepl_pkg
// shared constants, codes and types of the sharable exe page loader
// ----------------------------------------------------------------------------
package sepl_pkg;

  // image geometry, both powers of two
  localparam int unsigned PAGE_WORDS = 512;
  localparam int unsigned MAP_PAGES  = 512;

  localparam int WORD_W      = 36;
  localparam int HALF_W      = 18;
  localparam int MEM_PAGE_W  = 27;
  localparam int ADDR_W      = 36;
  localparam int DATA_W      = 36;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 72;
  localparam int KIND_W      = 2;

  localparam int OFF_W         = $clog2(PAGE_WORDS);
  localparam int MAP_IW        = $clog2(MAP_PAGES);
  localparam int unsigned POS_LIMIT = PAGE_WORDS * MAP_PAGES;
  localparam int POS_W         = $clog2(POS_LIMIT + 1);
  localparam int PG_W          = POS_W - OFF_W;
  localparam int RUN_CNT_W     = WORD_W - MEM_PAGE_W;
  localparam int RUN_W         = RUN_CNT_W + 1;
  localparam int RUN_FP_W      = MEM_PAGE_W + 1;
  localparam int MAP_ENTRY_W   = MEM_PAGE_W + 1;
  localparam int MAP_VALID_BIT = MEM_PAGE_W;

  localparam logic [HALF_W-1:0] TYPE_IGNORED   = 18'o1774;
  localparam logic [HALF_W-1:0] TYPE_ENTRY     = 18'o1775;
  localparam logic [HALF_W-1:0] TYPE_DIRECTORY = 18'o1776;
  localparam logic [HALF_W-1:0] TYPE_END       = 18'o1777;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DIR_FIRST,
    PH_DIR_SECOND,
    PH_ENTRY_LEN,
    PH_ENTRY_ADDR,
    PH_SKIP_BLOCK,
    PH_SKIP_PAGE,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_LOOKUP
  } st_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   data;
  } res_t;

  typedef struct packed {
    logic                   we;
    logic [MAP_IW-1:0]      addr;
    logic [MAP_ENTRY_W-1:0] data;
  } map_wr_t;

  typedef struct packed {
    logic clearing;
    logic expanding;
    logic res_pending;
  } ctrl_status_t;

endpackage

### hw/rtl/sharable_exe_page_loader_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharable_exe_page_loader_top
// loads a paged sharable executable image stream into memory write requests
// ----------------------------------------------------------------------------
//   channel  dir  fields
//   s_*      in   tdata: word[35:0], tlast: end_of_input
//   m_*      out  tdata: address[35:0], data[71:36]; tuser: kind[1:0]
//
// after reset the page map is cleared entry by entry, no request taken
// header, entry, skip and directory first words leave the parser idle, a data word
// passes through the lookup state, and a directory second word with a nonzero first
// page starts a run that writes one map entry per page, up to 512 pages, before the
// next request; a request that makes a result holds the input while the result moves
`include "sharable_exe_page_loader_top_macros.svh"

module sharable_exe_page_loader_top import sepl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // word[35:0], zero fill
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // address[35:0], data[71:36]
  output logic [KIND_W-1:0]    m_tuser    // kind[1:0]
);

  res_t                   res;
  logic                   res_take;
  ctrl_status_t           status;
  map_wr_t                map_wr;
  logic [MAP_IW-1:0]      map_raddr;
  logic [MAP_ENTRY_W-1:0] map_rdata;

  logic                   out_valid;
  kind_t                  out_kind;
  logic [ADDR_W-1:0]      out_addr;
  logic [DATA_W-1:0]      out_data;

  logic                   map_busy;
  logic                   res_stuck;

  sepl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_word   (s_tdata[WORD_W-1:0]),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .res       (res),
    .res_take  (res_take),
    .status    (status),
    .map_wr    (map_wr),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );

  sepl_map_ram u_map (
    .clk   (clk),
    .wr    (map_wr),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // output register
  assign res_take = res.valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_kind <= res.kind;
      out_addr <= res.address;
      out_data <= res.data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data, out_addr};
  assign m_tuser  = out_kind;

  assign map_busy  = status.clearing || status.expanding;
  assign res_stuck = status.res_pending && m_tvalid && !m_tready;

  `SEPL_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_tready, "request taken in map clear")
  `SEPL_ASSERT(a_no_req_while_busy, clk, rst, map_busy |-> !s_tready, "request taken while busy")
  `SEPL_ASSERT(a_result_held, clk, rst, res_stuck |=> status.res_pending, "result dropped")

endmodule

### hw/rtl/sepl_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepl_map_ram
// file page to memory page map, one write and one registered read port
// ----------------------------------------------------------------------------
module sepl_map_ram import sepl_pkg::*; (
  input  logic                   clk,
  input  map_wr_t                wr,
  input  logic [MAP_IW-1:0]      raddr,
  output logic [MAP_ENTRY_W-1:0] rdata
);

  logic [MAP_ENTRY_W-1:0] mem [MAP_PAGES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sepl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sepl_ctrl
// block parser and sequencer: map clear, header decode, run expansion, data lookup
// ----------------------------------------------------------------------------
module sepl_ctrl import sepl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [WORD_W-1:0]      in_word,
  input  logic                   in_last,
  output logic                   in_ready,
  output res_t                   res,
  input  logic                   res_take,
  output ctrl_status_t           status,
  output map_wr_t                map_wr,
  output logic [MAP_IW-1:0]      map_raddr,
  input  logic [MAP_ENTRY_W-1:0] map_rdata
);

  st_t                   state, state_next;
  phase_t                phase, phase_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic [HALF_W-1:0]     bwl, bwl_next;
  logic [MEM_PAGE_W-1:0] pfp, pfp_next;
  logic [WORD_W-1:0]     entry_length, entry_length_next;
  logic [WORD_W-1:0]     entry_address, entry_address_next;
  logic [RUN_FP_W-1:0]   run_fp, run_fp_next;
  logic [MEM_PAGE_W-1:0] run_mp, run_mp_next;
  logic [RUN_W-1:0]      run_left, run_left_next;
  logic [MAP_IW-1:0]     clr_idx, clr_idx_next;
  logic [OFF_W-1:0]      look_off, look_off_next;
  logic [WORD_W-1:0]     look_word, look_word_next;
  logic                  look_ok, look_ok_next;
  res_t                  res_next;

  logic                  accept;
  logic                  run_go;
  logic                  lookup_go;
  logic                  run_fp_ok;
  logic [POS_W-1:0]      pos_adv;
  logic [HALF_W-1:0]     blk_type;
  logic [HALF_W-1:0]     blk_len;
  logic [HALF_W-1:0]     blk_rest;

  assign accept    = in_valid && in_ready;
  assign run_fp_ok = run_fp < RUN_FP_W'(MAP_PAGES);
  assign pos_adv   = (pos < POS_W'(POS_LIMIT)) ? pos + 1'b1 : pos;
  assign blk_type  = in_word[WORD_W-1:HALF_W];
  assign blk_len   = in_word[HALF_W-1:0];
  assign blk_rest  = (blk_len != '0) ? blk_len - 1'b1 : '0;
  assign run_go    = accept && !in_last && (phase == PH_DIR_SECOND) && (pfp != '0);
  assign lookup_go = accept && !in_last && (phase == PH_DATA);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == MAP_IW'(MAP_PAGES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (run_go) begin
          state_next = ST_RUN;
        end else if (lookup_go) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_RUN: begin
        if (run_left == RUN_W'(1) || !run_fp_ok) state_next = ST_IDLE;
      end
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready           = 1'b0;
    map_wr             = '0;
    map_raddr          = pos[OFF_W +: MAP_IW];
    status.clearing    = 1'b0;
    status.expanding   = 1'b0;
    status.res_pending = res.valid;
    case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        map_wr.we       = 1'b1;
        map_wr.addr     = clr_idx;
      end
      ST_IDLE: begin
        in_ready = !res.valid;
      end
      ST_RUN: begin
        status.expanding = 1'b1;
        map_wr.we        = run_fp_ok;
        map_wr.addr      = run_fp[MAP_IW-1:0];
        map_wr.data      = {1'b1, run_mp};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    bwl_next           = bwl;
    pfp_next           = pfp;
    entry_length_next  = entry_length;
    entry_address_next = entry_address;
    run_fp_next        = run_fp;
    run_mp_next        = run_mp;
    run_left_next      = run_left;
    clr_idx_next       = clr_idx;
    look_off_next      = look_off;
    look_word_next     = look_word;
    look_ok_next       = look_ok;
    res_next           = res;
    if (res_take) res_next.valid = 1'b0;

    case (state)
      ST_CLEAR: begin
        clr_idx_next = clr_idx + 1'b1;
      end
      ST_RUN: begin
        run_fp_next   = run_fp + 1'b1;
        run_mp_next   = run_mp + 1'b1;
        run_left_next = run_left - 1'b1;
      end
      ST_LOOKUP: begin
        if (look_ok && map_rdata[MAP_VALID_BIT]) begin
          res_next.valid   = 1'b1;
          res_next.kind    = KIND_WRITE;
          res_next.address = ADDR_W'({map_rdata[MEM_PAGE_W-1:0], look_off});
          res_next.data    = look_word;
        end
      end
      default: begin
        clr_idx_next = clr_idx;
      end
    endcase

    if (accept) begin
      if (in_last) begin
        res_next.valid   = 1'b1;
        res_next.kind    = KIND_ENTRY;
        res_next.address = entry_address;
        res_next.data    = entry_length;
      end else begin
        pos_next = pos_adv;
        case (phase)
          PH_HEADER: begin
            if (blk_type == TYPE_DIRECTORY) begin
              bwl_next   = blk_rest;
              phase_next = (blk_rest != '0) ? PH_DIR_FIRST : PH_HEADER;
            end else if (blk_type == TYPE_ENTRY) begin
              phase_next = PH_ENTRY_LEN;
            end else if (blk_type == TYPE_END) begin
              phase_next = (pos_adv >= POS_W'(PAGE_WORDS)) ? PH_DATA : PH_SKIP_PAGE;
            end else begin
              if (blk_type != TYPE_IGNORED) begin
                res_next.valid   = 1'b1;
                res_next.kind    = KIND_UNKNOWN;
                res_next.address = ADDR_W'(blk_type);
                res_next.data    = '0;
              end
              bwl_next   = blk_rest;
              phase_next = (blk_rest != '0) ? PH_SKIP_BLOCK : PH_HEADER;
            end
          end
          PH_DIR_FIRST: begin
            pfp_next   = in_word[MEM_PAGE_W-1:0];
            phase_next = PH_DIR_SECOND;
          end
          PH_DIR_SECOND: begin
            run_fp_next   = {1'b0, pfp};
            run_mp_next   = in_word[MEM_PAGE_W-1:0];
            run_left_next = RUN_W'(in_word[WORD_W-1:MEM_PAGE_W]) + 1'b1;
            bwl_next      = (bwl > HALF_W'(2)) ? bwl - HALF_W'(2) : '0;
            phase_next    = (bwl > HALF_W'(2)) ? PH_DIR_FIRST : PH_HEADER;
          end
          PH_ENTRY_LEN: begin
            entry_length_next = in_word;
            phase_next        = PH_ENTRY_ADDR;
          end
          PH_ENTRY_ADDR: begin
            entry_address_next = in_word;
            phase_next         = PH_HEADER;
          end
          PH_SKIP_BLOCK: begin
            bwl_next = (bwl != '0) ? bwl - 1'b1 : '0;
            if (bwl <= HALF_W'(1)) phase_next = PH_HEADER;
          end
          PH_SKIP_PAGE: begin
            if (pos_adv >= POS_W'(PAGE_WORDS)) phase_next = PH_DATA;
          end
          default: begin
            look_off_next  = pos[OFF_W-1:0];
            look_ok_next   = pos[POS_W-1:OFF_W] < PG_W'(MAP_PAGES);
            look_word_next = in_word;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      phase         <= PH_HEADER;
      pos           <= '0;
      bwl           <= '0;
      pfp           <= '0;
      entry_length  <= '1;
      entry_address <= '1;
      clr_idx       <= '0;
      res.valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      pos           <= pos_next;
      bwl           <= bwl_next;
      pfp           <= pfp_next;
      entry_length  <= entry_length_next;
      entry_address <= entry_address_next;
      clr_idx       <= clr_idx_next;
      res.valid     <= res_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    run_fp      <= run_fp_next;
    run_mp      <= run_mp_next;
    run_left    <= run_left_next;
    look_off    <= look_off_next;
    look_word   <= look_word_next;
    look_ok     <= look_ok_next;
    res.kind    <= res_next.kind;
    res.address <= res_next.address;
    res.data    <= res_next.data;
  end

endmodule
